>>> design/gffa_pkg.sv
// gffa_pkg: shared types and codes for the grid flood fill block
// used by gffa_fill_seq, grid_flood_fill_area_top and the testbench; depends on nothing

package gffa_pkg;

   // fixed field widths of the request and response transfers
   localparam int COORD_W = 5;
   localparam int AREA_W  = 11;

   // area saturates at the largest value the response field can carry
   localparam logic [AREA_W-1:0] AREA_MAX = '1;

   // request kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_FILL = 1'b1;

   // one accepted request as seen by the sequencer
   typedef struct packed {
      logic               kind;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               cell_value;
   } req_item_type;

   // sequencer status towards the channel logic
   typedef struct packed {
      logic              idle;
      logic              done;
      logic [AREA_W-1:0] area;
   } seq_status_type;

endpackage

>>> design/gffa_ram.sv
// gffa_ram: simple dual-port synchronous ram, one write and one read port
// read data registered; no dependencies

module gffa_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/gffa_fill_seq.sv
// gffa_fill_seq: sequencer that owns the grid bit ram and the coordinate stack ram
// depends on gffa_pkg and gffa_ram

module gffa_fill_seq #(
   parameter int GRID_ROWS = 32,
   parameter int GRID_COLS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  gffa_pkg::req_item_type        item,
   input  logic                          out_free,
   output gffa_pkg::seq_status_type      status
);

   localparam int CELLS = GRID_ROWS * GRID_COLS;
   localparam int RW    = $clog2(GRID_ROWS);
   localparam int CW    = $clog2(GRID_COLS);
   localparam int AW    = $clog2(CELLS);
   localparam int SW    = RW + CW;

   localparam logic [RW-1:0] ROW_LAST  = RW'(GRID_ROWS - 1);
   localparam logic [CW-1:0] COL_LAST  = CW'(GRID_COLS - 1);
   localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
   localparam logic [AW-1:0] COLS_A    = AW'(GRID_COLS);
   localparam logic [8:0]    ROWS_LIM  = 9'(GRID_ROWS);
   localparam logic [8:0]    COLS_LIM  = 9'(GRID_COLS);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SEED  = 3'd2;
   localparam logic [2:0] ST_POP   = 3'd3;
   localparam logic [2:0] ST_NBR   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   localparam logic [2:0] NBR_LAST = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [AW-1:0]                clr_ff, clr_in;
   logic [AW:0]                  sp_ff, sp_in;
   logic [2:0]                   k_ff, k_in;
   logic [gffa_pkg::AREA_W-1:0]  count_ff, count_in;
   logic                         chk_valid_ff, chk_valid_in;
   logic [SW-1:0]                chk_rc_ff, chk_rc_in;
   logic [AW-1:0]                chk_addr_ff, chk_addr_in;
   logic                         seq_done;

   logic          g_we, g_wdata, g_re, g_rdata;
   logic [AW-1:0] g_waddr, g_raddr;
   logic          s_we, s_re;
   logic [AW-1:0] s_waddr, s_raddr;
   logic [SW-1:0] s_wdata, s_rdata;

   logic [7:0]    item_row_ext, item_col_ext;
   logic [RW-1:0] item_r;
   logic [CW-1:0] item_c;
   logic          item_in_range;
   logic [AW-1:0] item_addr;

   logic [RW-1:0] cur_r;
   logic [CW-1:0] cur_c;
   logic [RW-1:0] nb_r  [4];
   logic [CW-1:0] nb_c  [4];
   logic          nb_ok [4];
   logic [RW-1:0] sel_r;
   logic [CW-1:0] sel_c;
   logic          sel_ok;
   logic [AW-1:0] sel_addr;
   logic [AW:0]   sp_dec, sp_inc;
   logic [gffa_pkg::AREA_W-1:0] count_inc;

   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
      logic [AW-1:0] base;
      base = AW'(r) * COLS_A;
      return base + AW'(c);
   endfunction

   gffa_ram #(.WIDTH(1), .DEPTH(CELLS)) u_grid (
      .clock   (clock),
      .wr_en   (g_we),
      .wr_addr (g_waddr),
      .wr_data (g_wdata),
      .rd_en   (g_re),
      .rd_addr (g_raddr),
      .rd_data (g_rdata)
   );

   gffa_ram #(.WIDTH(SW), .DEPTH(CELLS)) u_stack (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_en   (s_re),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   // request coordinates, range test against the grid size
   assign item_row_ext  = {3'b000, item.row};
   assign item_col_ext  = {3'b000, item.col};
   assign item_r        = item_row_ext[RW-1:0];
   assign item_c        = item_col_ext[CW-1:0];
   assign item_in_range = ({1'b0, item_row_ext} < ROWS_LIM) && ({1'b0, item_col_ext} < COLS_LIM);
   assign item_addr     = cell_addr(item_r, item_c);

   // neighbours of the popped cell: down, up, right, left
   assign cur_r = s_rdata[SW-1:CW];
   assign cur_c = s_rdata[CW-1:0];

   always_comb begin
      nb_r[0]  = RW'(cur_r + 1'b1);
      nb_c[0]  = cur_c;
      nb_ok[0] = (cur_r != ROW_LAST);
      nb_r[1]  = RW'(cur_r - 1'b1);
      nb_c[1]  = cur_c;
      nb_ok[1] = (cur_r != '0);
      nb_r[2]  = cur_r;
      nb_c[2]  = CW'(cur_c + 1'b1);
      nb_ok[2] = (cur_c != COL_LAST);
      nb_r[3]  = cur_r;
      nb_c[3]  = CW'(cur_c - 1'b1);
      nb_ok[3] = (cur_c != '0);
   end

   assign sel_r    = nb_r[k_ff[1:0]];
   assign sel_c    = nb_c[k_ff[1:0]];
   assign sel_ok   = nb_ok[k_ff[1:0]];
   assign sel_addr = cell_addr(sel_r, sel_c);

   assign sp_dec    = (AW+1)'(sp_ff - 1'b1);
   assign sp_inc    = (AW+1)'(sp_ff + 1'b1);
   assign count_inc = (count_ff == gffa_pkg::AREA_MAX) ? count_ff
                    : gffa_pkg::AREA_W'(count_ff + 1'b1);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      sp_in        = sp_ff;
      k_in         = k_ff;
      count_in     = count_ff;
      chk_valid_in = chk_valid_ff;
      chk_rc_in    = chk_rc_ff;
      chk_addr_in  = chk_addr_ff;
      g_we         = 1'b0;
      g_waddr      = chk_addr_ff;
      g_wdata      = 1'b1;
      g_re         = 1'b0;
      g_raddr      = chk_addr_ff;
      s_we         = 1'b0;
      s_waddr      = sp_ff[AW-1:0];
      s_wdata      = chk_rc_ff;
      s_re         = 1'b0;
      s_raddr      = sp_dec[AW-1:0];
      seq_done     = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            g_we    = 1'b1;
            g_waddr = clr_ff;
            g_wdata = 1'b0;
            if (clr_ff == CELL_LAST) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = AW'(clr_ff + 1'b1);
            end
         end
         ST_IDLE: begin
            if (item_valid) begin
               if (item.kind == gffa_pkg::REQ_LOAD) begin
                  g_we    = item_in_range;
                  g_waddr = item_addr;
                  g_wdata = item.cell_value;
               end else begin
                  count_in = '0;
                  if (item_in_range) begin
                     g_re        = 1'b1;
                     g_raddr     = item_addr;
                     chk_addr_in = item_addr;
                     chk_rc_in   = {item_r, item_c};
                     state_in    = ST_SEED;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_SEED: begin
            // mark on push, so every cell enters the stack once
            if (!g_rdata) begin
               g_we     = 1'b1;
               s_we     = 1'b1;
               sp_in    = sp_inc;
               count_in = count_inc;
               state_in = ST_POP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_POP: begin
            if (sp_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               s_re         = 1'b1;
               sp_in        = sp_dec;
               k_in         = '0;
               chk_valid_in = 1'b0;
               state_in     = ST_NBR;
            end
         end
         ST_NBR: begin
            // check the neighbour read last cycle
            if (chk_valid_ff && !g_rdata) begin
               g_we     = 1'b1;
               s_we     = 1'b1;
               sp_in    = sp_inc;
               count_in = count_inc;
            end
            // issue the read of the next neighbour
            if (k_ff != NBR_LAST) begin
               chk_valid_in = sel_ok;
               g_re         = sel_ok;
               g_raddr      = sel_addr;
               chk_addr_in  = sel_addr;
               chk_rc_in    = {sel_r, sel_c};
               k_in         = 3'(k_ff + 1'b1);
            end else begin
               state_in = ST_POP;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               seq_done = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign status.done = seq_done;
   assign status.idle = (state_ff == ST_IDLE);
   assign status.area = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         sp_ff        <= '0;
         k_ff         <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         sp_ff        <= sp_in;
         k_ff         <= k_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      chk_rc_ff   <= chk_rc_in;
      chk_addr_ff <= chk_addr_in;
   end

endmodule

>>> design/grid_flood_fill_area_top.sv
// grid_flood_fill_area_top: four-connected flood fill over a bit grid
// depends on gffa_pkg, gffa_fill_seq and gffa_ram
//
// usage
//   request channel (req_*): req_type 0 writes req_cell_value into cell
//   (req_row, req_col); req_type 1 floods from that cell as seed
//   response channel (rsp_*): one transfer per fill carrying rsp_area, the
//   number of open cells newly marked; writes give no response
//   coordinates outside the grid: writes are dropped, fills report zero
// timing
//   a write does not stall, the next request can follow straight away
//   a fill pops each marked cell off the stack and reads its four
//   neighbours one after another through the single read port of the grid
//   ram; a seed that is already filled gives zero
//   one item at a time: req_stall is high from fill start until the result
//   has moved into the output register
// reset
//   grid is cleared to all open by a pass over all GRID_ROWS * GRID_COLS
//   cells while req_stall stays high
// stalls
//   the result waits in the output register; requests are still taken
//   meanwhile, a later fill holds its result until that register frees

module grid_flood_fill_area_top #(
   parameter int GRID_ROWS = 32,
   parameter int GRID_COLS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [gffa_pkg::COORD_W-1:0]  req_row,
   input  logic [gffa_pkg::COORD_W-1:0]  req_col,
   input  logic                          req_cell_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gffa_pkg::AREA_W-1:0]   rsp_area
);

   localparam int CELLS    = GRID_ROWS * GRID_COLS;
   localparam int AREA_TOP = (CELLS > 2047) ? 2047 : CELLS;
   localparam logic [gffa_pkg::AREA_W:0] AREA_CAP = (gffa_pkg::AREA_W + 1)'(AREA_TOP);

   gffa_pkg::req_item_type   item;
   gffa_pkg::seq_status_type seq_status;
   logic                     item_valid;
   logic                     out_free;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [gffa_pkg::AREA_W-1:0]   rsp_area_ff, rsp_area_in;

   // request transfer: only taken while the sequencer sits idle
   assign req_stall  = !seq_status.idle;
   assign item_valid = req_valid && !req_stall;

   assign item.kind       = req_type;
   assign item.row        = req_row;
   assign item.col        = req_col;
   assign item.cell_value = req_cell_value;

   // output register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   gffa_fill_seq #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_free   (out_free),
      .status     (seq_status)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_area_in  = rsp_area_ff;
      if (seq_status.done) begin
         rsp_valid_in = 1'b1;
         rsp_area_in  = seq_status.area;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_area_ff <= rsp_area_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_area  = rsp_area_ff;

   // the clearing pass holds off requests right after reset
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("request taken before grid clear finished");

   // a finished fill never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      seq_status.done |-> (!rsp_valid_ff || !rsp_stall))
      else $error("fill result overwrote a pending response");

   // area can never exceed the cell count
   a_area_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({1'b0, rsp_area_ff} <= AREA_CAP))
      else $error("reported area larger than the grid");

endmodule

>>> tb/gffa_area_checker.sv
// gffa_area_checker: watches both channels of the grid flood fill block and predicts every area
// depends on gffa_pkg; instantiated by tb beside the block

module gffa_area_checker #(
   parameter int GRID_ROWS = 32,
   parameter int GRID_COLS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_type,
   input  logic [gffa_pkg::COORD_W-1:0]  req_row,
   input  logic [gffa_pkg::COORD_W-1:0]  req_col,
   input  logic                          req_cell_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [gffa_pkg::AREA_W-1:0]   rsp_area,
   output int                            fail_count,
   output int                            pending_fills
);

   localparam int CELLS = GRID_ROWS * GRID_COLS;

   bit                          cell_taken [CELLS];
   int                          walk_stack [CELLS];
   int                          walk_depth;
   logic [gffa_pkg::AREA_W-1:0] areas_due [$];
   logic [gffa_pkg::AREA_W-1:0] want_area;

   // mark and push one cell if it lies in the grid and is still open
   function automatic int claim(int r, int c);
      int idx;
      if (r < 0 || r >= GRID_ROWS || c < 0 || c >= GRID_COLS) return 0;
      idx = r * GRID_COLS + c;
      if (cell_taken[idx]) return 0;
      cell_taken[idx] = 1'b1;
      walk_stack[walk_depth] = idx;
      walk_depth++;
      return 1;
   endfunction

   function automatic logic [gffa_pkg::AREA_W-1:0] flood_area(int r0, int c0);
      int count;
      int idx;
      int r;
      int c;
      walk_depth = 0;
      count = claim(r0, c0);
      while (walk_depth > 0) begin
         walk_depth--;
         idx = walk_stack[walk_depth];
         r = idx / GRID_COLS;
         c = idx % GRID_COLS;
         count += claim(r + 1, c);
         count += claim(r - 1, c);
         count += claim(r, c + 1);
         count += claim(r, c - 1);
      end
      if (count > int'(gffa_pkg::AREA_MAX)) count = int'(gffa_pkg::AREA_MAX);
      return count[gffa_pkg::AREA_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (cell_taken[i]) cell_taken[i] = 1'b0;
         areas_due.delete();
         fail_count <= 0;
         pending_fills <= 0;
      end else begin
         // response side first: a fill taken at this edge cannot answer at it
         if (rsp_valid && !rsp_stall) begin
            if (areas_due.size() == 0) begin
               $display("%0t: area transfer with no fill outstanding, expected none, got %0d",
                        $time, rsp_area);
               fail_count <= fail_count + 1;
            end else begin
               want_area = areas_due.pop_front();
               if (rsp_area !== want_area) begin
                  $display("%0t: area mismatch, expected %0d, got %0d",
                           $time, want_area, rsp_area);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_type == gffa_pkg::REQ_FILL) begin
               areas_due = {areas_due, flood_area(int'(req_row), int'(req_col))};
            end else if (req_row < GRID_ROWS && req_col < GRID_COLS) begin
               cell_taken[req_row * GRID_COLS + req_col] = req_cell_value;
            end
         end
         pending_fills <= areas_due.size();
      end
   end

endmodule

>>> tb/tb.sv
// tb: stimulus and verdict for grid_flood_fill_area_top
// depends on gffa_pkg, grid_flood_fill_area_top and gffa_area_checker

module tb;

   localparam int GRID_ROWS = 32;
   localparam int GRID_COLS = 32;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic                         req_type;
   logic [gffa_pkg::COORD_W-1:0] req_row;
   logic [gffa_pkg::COORD_W-1:0] req_col;
   logic                         req_cell_value;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [gffa_pkg::AREA_W-1:0]  rsp_area;

   int fail_count;
   int pending_fills;

   // sender bookkeeping
   int items_sent;
   int burst_left;

   // receiver stall pattern
   int stall_hold;
   int stall_free;

   grid_flood_fill_area_top #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_cell_value (req_cell_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_area       (rsp_area)
   );

   // the checker predicts and compares, the top only drives and judges
   gffa_area_checker #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS)
   ) chk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_cell_value (req_cell_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_area       (rsp_area),
      .fail_count     (fail_count),
      .pending_fills  (pending_fills)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // gap length shared by both sides: mostly none or short, now and then long
   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   // one request transfer; entered and left at a falling edge
   task automatic send_req(input logic kind, input int r, input int c, input int v);
      int gap;
      if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else begin
         gap = idle_len();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_row        <= gffa_pkg::COORD_W'(r);
      req_col        <= gffa_pkg::COORD_W'(c);
      req_cell_value <= 1'(v);
      // the transfer happens at the first rising edge with stall low
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // open every cell of a rectangle, row by row
   task automatic open_block(input int r0, input int c0, input int h, input int w);
      for (int r = r0; r < r0 + h; r++)
         for (int c = c0; c < c0 + w; c++)
            send_req(gffa_pkg::REQ_LOAD, r, c, 0);
   endtask

   // hold the sender off until every fill has answered
   task automatic drain_fills();
      req_valid <= 1'b0;
      wait (pending_fills == 0);
      @(negedge clock);
   endtask

   // receiver: free runs of random length, stalls in between, now and then a long calm
   initial begin
      rsp_stall  = 1'b0;
      stall_hold = 0;
      stall_free = 4;
      forever begin
         @(negedge clock);
         if (stall_hold > 0) begin
            rsp_stall <= 1'b1;
            stall_hold--;
         end else begin
            rsp_stall <= 1'b0;
            if (stall_free > 0) begin
               stall_free--;
            end else begin
               stall_hold = idle_len();
               stall_free = ($urandom_range(0, 15) == 0) ? 400 : $urandom_range(1, 20);
            end
         end
      end
   end

   // main stimulus
   initial begin
      int  h;
      int  w;
      int  r0;
      int  c0;
      int  pick;
      bit  drained;

      drained        = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = gffa_pkg::REQ_LOAD;
      req_row        = '0;
      req_col        = '0;
      req_cell_value = 1'b0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part
      // whole open grid from a corner seed: the largest area
      send_req(gffa_pkg::REQ_FILL, 0, 0, 0);
      // seed already filled, cell value ignored on a fill
      send_req(gffa_pkg::REQ_FILL, 31, 31, 1);
      // lone open cell in the far corner, all neighbours past the edge or filled
      open_block(31, 31, 1, 1);
      send_req(gffa_pkg::REQ_FILL, 31, 31, 0);
      // two by two pocket against the top and right edges
      open_block(0, 30, 2, 2);
      send_req(gffa_pkg::REQ_FILL, 1, 31, 0);
      // vertical pair against the left edge
      open_block(30, 0, 2, 1);
      send_req(gffa_pkg::REQ_FILL, 30, 0, 0);
      // open then block again: a blocked seed gives nothing
      send_req(gffa_pkg::REQ_LOAD, 16, 16, 0);
      send_req(gffa_pkg::REQ_LOAD, 16, 16, 1);
      send_req(gffa_pkg::REQ_FILL, 16, 16, 0);
      // short run split by a wall, both halves on their own
      open_block(10, 5, 1, 3);
      send_req(gffa_pkg::REQ_LOAD, 10, 6, 1);
      send_req(gffa_pkg::REQ_FILL, 10, 5, 0);
      send_req(gffa_pkg::REQ_FILL, 10, 7, 1);

      drain_fills();

      // random part: mostly carve a pocket and flood it, the rest noise
      while (items_sent < 140) begin
         if (!drained && items_sent >= 90) begin
            drain_fills();
            drained = 1'b1;
         end
         if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(10, 30);
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            h = $urandom_range(1, 3);
            w = $urandom_range(1, 4);
            // occasional long corridor so areas reach further
            if ($urandom_range(0, 7) == 0) begin
               if ($urandom_range(0, 1) == 1) begin
                  h = 1;
                  w = $urandom_range(8, 20);
               end else begin
                  h = $urandom_range(8, 20);
                  w = 1;
               end
            end
            r0 = $urandom_range(0, GRID_ROWS - h);
            c0 = $urandom_range(0, GRID_COLS - w);
            open_block(r0, c0, h, w);
            // sometimes drop a wall inside the pocket
            if ($urandom_range(0, 2) == 0)
               send_req(gffa_pkg::REQ_LOAD, r0 + $urandom_range(0, h - 1),
                        c0 + $urandom_range(0, w - 1), 1);
            send_req(gffa_pkg::REQ_FILL, r0 + $urandom_range(0, h - 1),
                     c0 + $urandom_range(0, w - 1), $urandom_range(0, 1));
         end else if (pick < 80) begin
            send_req(gffa_pkg::REQ_LOAD, $urandom_range(0, GRID_ROWS - 1),
                     $urandom_range(0, GRID_COLS - 1), $urandom_range(0, 1));
         end else begin
            send_req(gffa_pkg::REQ_FILL, $urandom_range(0, GRID_ROWS - 1),
                     $urandom_range(0, GRID_COLS - 1), $urandom_range(0, 1));
         end
      end

      // let the last fills answer, then a short tail for stray transfers
      req_valid <= 1'b0;
      wait (pending_fills == 0);
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending_fills == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin
      #50000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> files.f
design/gffa_pkg.sv
design/gffa_ram.sv
design/gffa_fill_seq.sv
design/grid_flood_fill_area_top.sv
tb/gffa_area_checker.sv
tb/tb.sv
